/* sv/dlp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlp_pkg: shared types and constants of the lease pool
// Request and reply codes, register indexes, reset values and the
// sequencer state type.
// ----------------------------------------------------------------------------
package dlp_pkg;

	// Table size
	localparam int ENTRIES_DEF = 8;

	// Field widths
	localparam int KIND_W = 2;
	localparam int MAC_W  = 48;
	localparam int XID_W  = 32;
	localparam int ADDR_W = 32;
	localparam int AGE_W  = 16;
	localparam int DATA_W = 80;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Request kinds
	localparam logic [KIND_W-1:0] REQ_DISCOVER = 2'd0;
	localparam logic [KIND_W-1:0] REQ_REQUEST  = 2'd1;
	localparam logic [KIND_W-1:0] REQ_TICK     = 2'd2;

	// Reply kinds
	localparam logic [KIND_W-1:0] REPLY_OFFER = 2'd0;
	localparam logic [KIND_W-1:0] REPLY_ACK   = 2'd1;
	localparam logic [KIND_W-1:0] REPLY_NAK   = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_START = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_END   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LEASE_TIME  = 2'd2;

	// Register reset values
	localparam logic [ADDR_W-1:0] RANGE_START_RST = 32'hC0A8_0003;
	localparam logic [ADDR_W-1:0] RANGE_END_RST   = 32'hC0A8_006E;
	localparam logic [AGE_W-1:0]  LEASE_TIME_RST  = 16'd60;

	// Sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_DECODE,
		S_SEARCH,
		S_REPLY
	} dlp_state_t;

endpackage

/* sv/dhcp_lease_pool.sv */
`timescale 1ns / 1ps
// Sequence: a tick or an ignored item passes through decode and frees the block;
// a request or a discover whose client already holds an address passes decode
// and then the reply state; a discover that searches passes through the search state,
// one cycle per candidate address through the single candidate incrementer.
// Throughput: one item at a time; s_tready is high only while the sequencer idles.
// Reset: arst_n clears every slot, last offer and registers to their defaults at once.
// ----------------------------------------------------------------------------
// dhcp_lease_pool: lease table of a pool server
// Slots hold address, client MAC, transaction id and age. A sequencer
// decodes each item, steps one candidate address per cycle against all
// slots for a free address, and registers the reply.
// ----------------------------------------------------------------------------
module dhcp_lease_pool #(
	parameter int ENTRIES = dlp_pkg::ENTRIES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Input items
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [dlp_pkg::DATA_W-1:0]      s_tdata,   // mac[47:0], xid[79:48]
	input  logic [dlp_pkg::KIND_W-1:0]      s_tuser,   // req_type[1:0]
	// Result items
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [dlp_pkg::DATA_W-1:0]      m_tdata,   // ip_addr[31:0], mac_echo[79:32]
	output logic [dlp_pkg::KIND_W-1:0]      m_tuser,   // reply_kind[1:0]
	// Configuration writes
	input  logic                            cfg_we,
	input  logic [dlp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dlp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 2);
	localparam int AW    = dlp_pkg::ADDR_W;
	localparam int MW    = dlp_pkg::MAC_W;
	localparam int XW    = dlp_pkg::XID_W;
	localparam int GW    = dlp_pkg::AGE_W;
	localparam int KW    = dlp_pkg::KIND_W;

	dlp_pkg::dlp_state_t state_q, state_d;

	// Captured item
	logic [KW-1:0] kind_q;
	logic [MW-1:0] mac_q;
	logic [XW-1:0] xid_q;

	// Configuration
	logic [AW-1:0] range_start_q;
	logic [AW-1:0] range_end_q;
	logic [GW-1:0] lease_time_q;

	// Lease table
	logic [AW-1:0] slot_addr_q [ENTRIES];
	logic [MW-1:0] slot_mac_q  [ENTRIES];
	logic [XW-1:0] slot_xid_q  [ENTRIES];
	logic [GW-1:0] slot_age_q  [ENTRIES];
	logic [AW-1:0] last_offer_q;

	// Search unit
	logic [AW:0]      cand_q;
	logic [CNT_W-1:0] cnt_q;

	// Pending reply and output register
	logic [KW-1:0] res_kind_q;
	logic [AW-1:0] res_addr_q;
	logic          m_tvalid_q;
	logic [KW-1:0] m_kind_q;
	logic [AW-1:0] m_addr_q;
	logic [MW-1:0] m_mac_q;

	// Per-slot compare results
	logic [ENTRIES-1:0] mac_eq, dup_eq, held, empty, req_eq;
	logic [GW-1:0]      age_inc [ENTRIES];
	logic               dup_any, held_any, search_end;
	logic               mac_any, req_any, free_any;
	logic [IDX_W-1:0]   mac_idx, req_idx, free_idx;
	logic [AW-1:0]      mac_addr;

	// Sequencer strobes
	logic          do_tick, do_req_clr, do_record;
	logic          res_load, offer_load, cand_init, cand_step, out_load;
	logic [KW-1:0] res_kind_d;
	logic [AW-1:0] res_addr_d, offer_d;

	// Compare every slot against the captured item and the candidate
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			mac_eq[i]  = (slot_mac_q[i] == mac_q);
			dup_eq[i]  = mac_eq[i] && (slot_xid_q[i] == xid_q);
			empty[i]   = (slot_addr_q[i] == '0);
			held[i]    = !empty[i] && (slot_addr_q[i] == cand_q[AW-1:0]);
			req_eq[i]  = mac_eq[i] && (slot_addr_q[i] == last_offer_q);
			age_inc[i] = (slot_age_q[i] == '1) ? slot_age_q[i] : slot_age_q[i] + GW'(1);
		end
	end

	assign dup_any    = |dup_eq;
	assign held_any   = |held;
	assign search_end = (cand_q > {1'b0, range_end_q}) || (cnt_q > CNT_W'(ENTRIES));

	// Pick the lowest slot of each match vector
	always_comb begin
		mac_any  = 1'b0;
		req_any  = 1'b0;
		free_any = 1'b0;
		mac_idx  = '0;
		req_idx  = '0;
		free_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (mac_eq[i]) begin
				mac_any = 1'b1;
				mac_idx = IDX_W'(i);
			end
			if (req_eq[i]) begin
				req_any = 1'b1;
				req_idx = IDX_W'(i);
			end
			if (empty[i]) begin
				free_any = 1'b1;
				free_idx = IDX_W'(i);
			end
		end
	end

	assign mac_addr = slot_addr_q[mac_idx];

	// Next state and strobes
	always_comb begin
		state_d    = state_q;
		do_tick    = 1'b0;
		do_req_clr = 1'b0;
		do_record  = 1'b0;
		res_load   = 1'b0;
		res_kind_d = dlp_pkg::REPLY_OFFER;
		res_addr_d = '0;
		offer_load = 1'b0;
		offer_d    = '0;
		cand_init  = 1'b0;
		cand_step  = 1'b0;
		out_load   = 1'b0;
		unique case (state_q)
			dlp_pkg::S_IDLE: begin
				if (s_tvalid) state_d = dlp_pkg::S_DECODE;
			end
			dlp_pkg::S_DECODE: begin
				unique case (kind_q)
					dlp_pkg::REQ_TICK: begin
						do_tick = 1'b1;
						state_d = dlp_pkg::S_IDLE;
					end
					dlp_pkg::REQ_REQUEST: begin
						do_req_clr = req_any;
						res_load   = 1'b1;
						res_kind_d = dlp_pkg::REPLY_ACK;
						res_addr_d = last_offer_q;
						state_d    = dlp_pkg::S_REPLY;
					end
					dlp_pkg::REQ_DISCOVER: begin
						if (dup_any) begin
							state_d = dlp_pkg::S_IDLE;
						end else if (mac_any && mac_addr != '0) begin
							res_load   = 1'b1;
							res_kind_d = dlp_pkg::REPLY_OFFER;
							res_addr_d = mac_addr;
							offer_load = 1'b1;
							offer_d    = mac_addr;
							state_d    = dlp_pkg::S_REPLY;
						end else begin
							cand_init = 1'b1;
							state_d   = dlp_pkg::S_SEARCH;
						end
					end
					default: state_d = dlp_pkg::S_IDLE;
				endcase
			end
			dlp_pkg::S_SEARCH: begin
				if (search_end) begin
					res_load   = 1'b1;
					res_kind_d = dlp_pkg::REPLY_NAK;
					offer_load = 1'b1;
					state_d    = dlp_pkg::S_REPLY;
				end else if (!held_any) begin
					do_record  = free_any;
					res_load   = 1'b1;
					res_kind_d = dlp_pkg::REPLY_OFFER;
					res_addr_d = cand_q[AW-1:0];
					offer_load = 1'b1;
					offer_d    = cand_q[AW-1:0];
					state_d    = dlp_pkg::S_REPLY;
				end else begin
					cand_step = 1'b1;
				end
			end
			dlp_pkg::S_REPLY: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = dlp_pkg::S_IDLE;
				end
			end
			default: state_d = dlp_pkg::S_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dlp_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Capture the item on accept
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_q <= s_tuser;
			mac_q  <= s_tdata[MW-1:0];
			xid_q  <= s_tdata[MW+XW-1:MW];
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_start_q <= dlp_pkg::RANGE_START_RST;
			range_end_q   <= dlp_pkg::RANGE_END_RST;
			lease_time_q  <= dlp_pkg::LEASE_TIME_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dlp_pkg::CFG_RANGE_START: range_start_q <= cfg_wdata[AW-1:0];
				dlp_pkg::CFG_RANGE_END:   range_end_q   <= cfg_wdata[AW-1:0];
				dlp_pkg::CFG_LEASE_TIME:  lease_time_q  <= cfg_wdata[GW-1:0];
				default: ;
			endcase
		end
	end

	// Lease table: age and expire on tick, restart on request, record on offer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRIES; i++) begin
				slot_addr_q[i] <= '0;
				slot_mac_q[i]  <= '0;
				slot_xid_q[i]  <= '0;
				slot_age_q[i]  <= '0;
			end
		end else begin
			if (do_tick) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (!empty[i] && age_inc[i] > lease_time_q) begin
						slot_addr_q[i] <= '0;
						slot_mac_q[i]  <= '0;
						slot_xid_q[i]  <= '0;
						slot_age_q[i]  <= '0;
					end else begin
						slot_age_q[i] <= age_inc[i];
					end
				end
			end
			if (do_req_clr) slot_age_q[req_idx] <= '0;
			if (do_record) begin
				slot_addr_q[free_idx] <= cand_q[AW-1:0];
				slot_mac_q[free_idx]  <= mac_q;
				slot_xid_q[free_idx]  <= xid_q;
				slot_age_q[free_idx]  <= '0;
			end
		end
	end

	// Last offered address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_offer_q <= '0;
		end else if (offer_load) begin
			last_offer_q <= offer_d;
		end
	end

	// Candidate incrementer: start at range_start (or one), advance per cycle
	always_ff @(posedge clk) begin
		if (cand_init) begin
			cand_q <= {1'b0, (range_start_q == '0) ? AW'(1) : range_start_q};
			cnt_q  <= '0;
		end else if (cand_step) begin
			cand_q <= cand_q + (AW+1)'(1);
			cnt_q  <= cnt_q + CNT_W'(1);
		end
	end

	// Hold the reply until the output register frees
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_kind_q <= res_kind_d;
			res_addr_q <= res_addr_d;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_kind_q <= res_kind_q;
			m_addr_q <= res_addr_q;
			m_mac_q  <= mac_q;
		end
	end

	assign s_tready = (state_q == dlp_pkg::S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_kind_q;
	assign m_tdata  = {m_mac_q, m_addr_q};

endmodule

/* sv/dlp_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlp_checker: port-level checks of the lease pool
// Watches the handshakes and reply contents and is bound to the top level.
// ----------------------------------------------------------------------------
module dlp_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [dlp_pkg::DATA_W-1:0]      m_tdata,
	input  logic [dlp_pkg::KIND_W-1:0]      m_tuser
);

	// Hold a stalled reply
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("reply changed while stalled");

	// Go busy after every accepted item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted while the previous one is in work");

	// A nak carries address zero
	a_nak_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == dlp_pkg::REPLY_NAK |-> m_tdata[31:0] == '0)
		else $error("nak with nonzero address");

	// An offer never hands out address zero
	a_offer_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == dlp_pkg::REPLY_OFFER |-> m_tdata[31:0] != '0)
		else $error("offer of address zero");

	// Reply kind is always a defined code
	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser == dlp_pkg::REPLY_OFFER || m_tuser == dlp_pkg::REPLY_ACK ||
			m_tuser == dlp_pkg::REPLY_NAK)
		else $error("undefined reply kind");

endmodule

bind dhcp_lease_pool dlp_checker u_dlp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the lease pool
// Streams discovers, requests and ticks into the pool and predicts every
// offer, ack and nak from a private copy of the lease table. Replies are
// compared in order, field by field. The run steps through several pool
// ranges and lease lengths, including empty, inverted and top-of-space
// ranges, and a tick burst under the longest lease.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int ENTRIES = dlp_pkg::ENTRIES_DEF;
	localparam int KIND_W = dlp_pkg::KIND_W;
	localparam int MAC_W = dlp_pkg::MAC_W;
	localparam int XID_W = dlp_pkg::XID_W;
	localparam int ADDR_W = dlp_pkg::ADDR_W;
	localparam int AGE_W = dlp_pkg::AGE_W;
	localparam int DATA_W = dlp_pkg::DATA_W;
	localparam int CFG_IDX_W = dlp_pkg::CFG_IDX_W;
	localparam int CFG_DATA_W = dlp_pkg::CFG_DATA_W;
	localparam int SETTLE_CYCLES = ENTRIES + 6;
	localparam logic [KIND_W-1:0] REQ_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam logic [MAC_W-1:0] CLIENT_OUI = 48'h02C0_FFEE_0000;
	localparam logic [MAC_W-1:0] MAC_ONES = '1;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [MAC_W-1:0]  mac;
		logic [XID_W-1:0]  xid;
	} lease_req_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ADDR_W-1:0] ip;
		logic [MAC_W-1:0]  mac;
	} lease_reply_t;

	logic clk;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [DATA_W-1:0] s_tdata = '0;
	logic [KIND_W-1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [DATA_W-1:0] m_tdata;
	logic [KIND_W-1:0] m_tuser;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	// Predicted lease table and register copies
	logic [ADDR_W-1:0] lease_addr [ENTRIES] = '{default: '0};
	logic [MAC_W-1:0]  lease_mac  [ENTRIES] = '{default: '0};
	logic [XID_W-1:0]  lease_xid  [ENTRIES] = '{default: '0};
	logic [AGE_W-1:0]  lease_age  [ENTRIES] = '{default: '0};
	logic [ADDR_W-1:0] last_offer_addr = '0;
	logic [ADDR_W-1:0] pool_lo = dlp_pkg::RANGE_START_RST;
	logic [ADDR_W-1:0] pool_hi = dlp_pkg::RANGE_END_RST;
	logic [AGE_W-1:0]  lease_len = dlp_pkg::LEASE_TIME_RST;

	lease_req_t   pending_items [$];
	lease_reply_t expected_replies [$];
	lease_req_t   drv_item;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int fail_count = 0;

	dhcp_lease_pool #(.ENTRIES(ENTRIES)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Apply one accepted item to the predicted table and queue its reply
	function automatic void predict_lease(input logic [KIND_W-1:0] kind,
			input logic [MAC_W-1:0] mac, input logic [XID_W-1:0] xid);
		lease_reply_t rep;
		logic [ADDR_W-1:0] addr;
		logic [ADDR_W:0] first;
		logic [ADDR_W:0] cand;
		bit dup, hit, stop, taken, placed;
		rep.mac = mac;
		case (kind)
		dlp_pkg::REQ_TICK: begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (lease_age[i] != '1)
					lease_age[i]++;
				if (lease_addr[i] != '0 && lease_age[i] > lease_len) begin
					lease_addr[i] = '0;
					lease_mac[i] = '0;
					lease_xid[i] = '0;
					lease_age[i] = '0;
				end
			end
		end
		dlp_pkg::REQ_DISCOVER: begin
			// empty slots take part in both lookups
			dup = 1'b0;
			for (int i = 0; i < ENTRIES; i++)
				if (lease_mac[i] == mac && lease_xid[i] == xid)
					dup = 1'b1;
			if (!dup) begin
				addr = '0;
				hit = 1'b0;
				for (int i = 0; i < ENTRIES; i++)
					if (!hit && lease_mac[i] == mac) begin
						addr = lease_addr[i];
						hit = 1'b1;
					end
				if (addr == '0) begin
					// bounded search from the range base, never past the top
					first = (pool_lo == '0) ? (ADDR_W+1)'(1) : {1'b0, pool_lo};
					stop = 1'b0;
					for (int k = 0; k <= ENTRIES; k++) begin
						if (addr == '0 && !stop) begin
							cand = first + (ADDR_W+1)'(k);
							if (cand > {1'b0, pool_hi})
								stop = 1'b1;
							else begin
								taken = 1'b0;
								for (int j = 0; j < ENTRIES; j++)
									if (lease_addr[j] != '0 && lease_addr[j] == cand[ADDR_W-1:0])
										taken = 1'b1;
								if (!taken)
									addr = cand[ADDR_W-1:0];
							end
						end
					end
					if (addr != '0) begin
						placed = 1'b0;
						for (int i = 0; i < ENTRIES; i++)
							if (!placed && lease_addr[i] == '0) begin
								lease_addr[i] = addr;
								lease_mac[i] = mac;
								lease_xid[i] = xid;
								lease_age[i] = '0;
								placed = 1'b1;
							end
					end
				end
				last_offer_addr = addr;
				rep.kind = (addr == '0) ? dlp_pkg::REPLY_NAK : dlp_pkg::REPLY_OFFER;
				rep.ip = addr;
				expected_replies.push_back(rep);
			end
		end
		dlp_pkg::REQ_REQUEST: begin
			placed = 1'b0;
			for (int i = 0; i < ENTRIES; i++)
				if (!placed && lease_mac[i] == mac && lease_addr[i] == last_offer_addr) begin
					lease_age[i] = '0;
					placed = 1'b1;
				end
			rep.kind = dlp_pkg::REPLY_ACK;
			rep.ip = last_offer_addr;
			expected_replies.push_back(rep);
		end
		default: ;
		endcase
	endfunction

	function automatic void push_item(input logic [KIND_W-1:0] kind,
			input logic [MAC_W-1:0] mac, input logic [XID_W-1:0] xid);
		lease_req_t it;
		it.kind = kind;
		it.mac = mac;
		it.xid = xid;
		pending_items.push_back(it);
	endfunction

	// Mostly a small client population so that leases collide and the table fills
	function automatic logic [MAC_W-1:0] pick_client();
		if ($urandom_range(9) == 0)
			return MAC_W'({$urandom(), $urandom()});
		return CLIENT_OUI | MAC_W'($urandom_range(11));
	endfunction

	function automatic void queue_random_items(input int count);
		int made, pick, n;
		logic [MAC_W-1:0] mac;
		logic [XID_W-1:0] xid;
		made = 0;
		while (made < count) begin
			pick = $urandom_range(99);
			mac = pick_client();
			xid = ($urandom_range(3) == 0) ? XID_W'($urandom()) : XID_W'($urandom_range(2));
			if (pick < 50) begin
				// discover then request, now and then a repeated discover
				push_item(dlp_pkg::REQ_DISCOVER, mac, xid);
				made++;
				if ($urandom_range(9) == 0) begin
					push_item(dlp_pkg::REQ_DISCOVER, mac, xid);
					made++;
				end
				if ($urandom_range(9) < 8) begin
					push_item(dlp_pkg::REQ_REQUEST, mac, xid);
					made++;
				end
			end else if (pick < 60) begin
				push_item(dlp_pkg::REQ_REQUEST, mac, xid);
				made++;
			end else if (pick < 85) begin
				n = $urandom_range(1, 3);
				repeat (n) begin
					push_item(dlp_pkg::REQ_TICK, MAC_W'({$urandom(), $urandom()}),
						XID_W'($urandom()));
					made++;
				end
			end else if (pick < 95) begin
				push_item(dlp_pkg::REQ_DISCOVER, mac, xid);
				made++;
			end else
				push_item(REQ_UNUSED, MAC_W'({$urandom(), $urandom()}), XID_W'($urandom()));
		end
	endfunction

	// Hold until the pool is drained and the sequencer has settled
	task automatic wait_quiet();
		do
			@(posedge clk);
		while (pending_items.size() != 0 || s_tvalid || expected_replies.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		case (idx)
		dlp_pkg::CFG_RANGE_START: pool_lo = value;
		dlp_pkg::CFG_RANGE_END:   pool_hi = value;
		dlp_pkg::CFG_LEASE_TIME:  lease_len = value[AGE_W-1:0];
		default: ;
		endcase
	endtask

	task automatic set_pool(input logic [ADDR_W-1:0] lo, input logic [ADDR_W-1:0] hi,
			input logic [AGE_W-1:0] len);
		wait_quiet();
		write_reg(dlp_pkg::CFG_RANGE_START, lo);
		write_reg(dlp_pkg::CFG_RANGE_END, hi);
		write_reg(dlp_pkg::CFG_LEASE_TIME, CFG_DATA_W'(len));
		write_reg(CFG_UNUSED, CFG_DATA_W'($urandom()));
		cfg_we <= 1'b0;
	endtask

	// Driver: predict on accept, then load the next item unless idling
	always @(posedge clk) begin
		if (s_tvalid && s_tready)
			predict_lease(s_tuser, s_tdata[MAC_W-1:0], s_tdata[MAC_W +: XID_W]);
		if (!s_tvalid || s_tready) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				drv_item = pending_items.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {drv_item.xid, drv_item.mac};
				s_tuser <= drv_item.kind;
			end else
				s_tvalid <= 1'b0;
		end
	end

	// Monitor: compare each reply item against the oldest prediction
	always @(posedge clk) begin : reply_monitor
		lease_reply_t got, want;
		if (m_tvalid && m_tready) begin
			got.kind = m_tuser;
			got.ip = m_tdata[ADDR_W-1:0];
			got.mac = m_tdata[ADDR_W +: MAC_W];
			if (expected_replies.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("unexpected reply: kind %0d ip %h mac %h", got.kind, got.ip, got.mac);
			end else begin
				want = expected_replies.pop_front();
				if (got.kind !== want.kind || got.ip !== want.ip || got.mac !== want.mac) begin
					fail_count++;
					if (fail_count <= 10)
						$display("reply mismatch: expected kind %0d ip %h mac %h, got kind %0d ip %h mac %h",
							want.kind, want.ip, want.mac, got.kind, got.ip, got.mac);
				end
			end
		end
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	initial begin
		send_idle_pct = 9;
		recv_idle_pct = 59;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset pool settings
		push_item(dlp_pkg::REQ_REQUEST, MAC_ONES, '1);       // ack before any offer
		push_item(dlp_pkg::REQ_DISCOVER, '0, '0);            // matches an empty slot, dropped
		push_item(dlp_pkg::REQ_DISCOVER, '0, 32'd7);         // MAC hits an empty slot, searches
		push_item(dlp_pkg::REQ_DISCOVER, MAC_ONES, '1);
		push_item(dlp_pkg::REQ_DISCOVER, MAC_ONES, '1);      // duplicate, dropped
		push_item(dlp_pkg::REQ_DISCOVER, MAC_ONES, 32'd1);   // re-offer held address
		push_item(dlp_pkg::REQ_REQUEST, MAC_ONES, 32'd1);
		push_item(dlp_pkg::REQ_TICK, MAC_ONES, '1);
		push_item(REQ_UNUSED, MAC_ONES, '1);

		// Directed: top of the address space, no wrap
		set_pool(32'hFFFF_FFFE, 32'hFFFF_FFFF, 16'hFFFF);
		push_item(dlp_pkg::REQ_DISCOVER, 48'h0123_4567_89AB, 32'd2);
		push_item(dlp_pkg::REQ_DISCOVER, 48'hA5A5_A5A5_A5A5, 32'hA5A5_A5A5);
		push_item(dlp_pkg::REQ_DISCOVER, 48'h5A5A_5A5A_5A5A, 32'h5A5A_5A5A);
		push_item(dlp_pkg::REQ_REQUEST, 48'h5A5A_5A5A_5A5A, 32'h5A5A_5A5A);   // ack after nak

		// Directed: base zero, shortest lease
		set_pool('0, 32'd4, 16'd1);
		push_item(dlp_pkg::REQ_DISCOVER, 48'h1, 32'd9);
		push_item(dlp_pkg::REQ_TICK, '0, '0);
		push_item(dlp_pkg::REQ_TICK, '0, '0);
		push_item(dlp_pkg::REQ_DISCOVER, 48'h2, 32'd9);

		// Directed: inverted range, end at zero
		set_pool(32'd10, '0, 16'd60);
		push_item(dlp_pkg::REQ_DISCOVER, 48'h3, 32'd4);
		push_item(dlp_pkg::REQ_REQUEST, 48'h3, 32'd4);

		// Random: tiny pool from base zero
		set_pool('0, 32'd5, 16'd3);
		queue_random_items(330);

		send_idle_pct = 59;
		recv_idle_pct = 9;
		set_pool(32'hFFFF_FFF9, 32'hFFFF_FFFF, 16'd1);
		queue_random_items(170);
		set_pool(32'd256, 32'hFFFF_FFFF, 16'd20);
		queue_random_items(160);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_pool(dlp_pkg::RANGE_START_RST, dlp_pkg::RANGE_END_RST, 16'd8);
		queue_random_items(340);

		// Tick burst under the longest lease keeps every lease alive
		set_pool(dlp_pkg::RANGE_START_RST, dlp_pkg::RANGE_END_RST, 16'hFFFF);
		push_item(dlp_pkg::REQ_DISCOVER, CLIENT_OUI | 48'd20, 32'd1);
		push_item(dlp_pkg::REQ_REQUEST, CLIENT_OUI | 48'd20, 32'd1);
		push_item(dlp_pkg::REQ_DISCOVER, CLIENT_OUI | 48'd21, 32'd1);
		repeat (10) push_item(dlp_pkg::REQ_TICK, '0, '0);
		push_item(dlp_pkg::REQ_DISCOVER, CLIENT_OUI | 48'd21, 32'd2);
		push_item(dlp_pkg::REQ_REQUEST, CLIENT_OUI | 48'd21, 32'd2);
		push_item(dlp_pkg::REQ_DISCOVER, CLIENT_OUI | 48'd22, 32'd1);
		push_item(dlp_pkg::REQ_TICK, '0, '0);
		push_item(dlp_pkg::REQ_REQUEST, CLIENT_OUI | 48'd20, 32'd1);

		wait_quiet();
		if (fail_count == 0 && expected_replies.size() == 0)
			$display("dhcp_lease_pool test passed");
		else
			$display("dhcp_lease_pool test failed");
		$finish;
	end

	// Watchdog
	initial begin
		#40_000_000;
		$display("dhcp_lease_pool test failed");
		$finish;
	end

endmodule

/* filelist.f */
sv/dlp_pkg.sv
sv/dhcp_lease_pool.sv
sv/dlp_checker.sv
sim/tb_top.sv
